>>> rtl/core/page_color_histogram_macros.svh
// Assertion shorthands for the page color histogram.
`ifndef PAGE_COLOR_HISTOGRAM_MACROS_SVH
`define PAGE_COLOR_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCH_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page_color_histogram: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page_color_histogram: assertion failed");

`endif

>>> rtl/core/pch_pkg.sv
package pch_pkg;

    localparam int NUM_COLORS_DEF       = 32;
    localparam int COUNT_WIDTH_DEF      = 32;
    localparam int PAGE_OFFSET_BITS_DEF = 12;
    localparam int FRAME_BITS_DEF       = 55;

    localparam int COLOR_BITS  = 5;
    localparam int COLOR_SPAN  = 1 << COLOR_BITS;
    localparam int MASK_BITS   = 32;
    localparam int ENTRY_BITS  = 64;
    localparam int PRESENT_BIT = 63;
    localparam int OUT_BITS    = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MASK_BITS-1:0] COLOR_MASK_RESET = 32'h0001_c000;

    typedef struct packed {
        logic                  action;
        logic [ENTRY_BITS-1:0] map_entry;
        logic [COLOR_BITS-1:0] bin_select;
    } t_item;

    typedef struct packed {
        logic                  counted;
        logic [COLOR_BITS-1:0] color;
        logic [OUT_BITS-1:0]   bin_count;
        logic [OUT_BITS-1:0]   total_count;
    } t_result;

    typedef enum logic [1:0] {
        OP_SKIP,
        OP_ADD,
        OP_READ
    } t_op;

    // Classified item passed from front to back.
    typedef struct packed {
        t_op                   op;
        logic [COLOR_BITS-1:0] color;
        logic [COLOR_BITS-1:0] slot;
        logic                  slot_ok;
    } t_cmd;

    // Per mask bit: one-hot color bit it feeds, zero if unused.
    typedef logic [MASK_BITS-1:0][COLOR_BITS-1:0] t_route;

    function automatic t_route color_route(input logic [MASK_BITS-1:0] mask,
                                           input int unsigned offset);
        logic [MASK_BITS-1:0] usable;
        logic [MASK_BITS-1:0] below;
        int unsigned          rank;
        t_route               route;
        usable = mask & ~((32'd1 << offset) - 32'd1);
        for (int c = 0; c < MASK_BITS; c++) begin
            below    = usable & ((32'd1 << c) - 32'd1);
            rank     = $countones(below);
            route[c] = '0;
            if (usable[c] && rank < COLOR_BITS) begin
                route[c][3'(rank)] = 1'b1;
            end
        end
        return route;
    endfunction

    function automatic logic [OUT_BITS-1:0] out_count(input logic [63:0] value);
        return value[OUT_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/pch_front.sv
module pch_front #(
    parameter int NUM_COLORS       = pch_pkg::NUM_COLORS_DEF,
    parameter int PAGE_OFFSET_BITS = pch_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int FRAME_BITS       = pch_pkg::FRAME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pch_pkg::MASK_BITS-1:0]  i_cfg_wdata,
    input  pch_pkg::t_item                 i_item,
    output pch_pkg::t_cmd                  o_cmd
);

    pch_pkg::t_route                   r_route;
    logic [FRAME_BITS-1:0]             frame;
    logic [pch_pkg::MASK_BITS-1:0]     fbit;
    logic [pch_pkg::COLOR_BITS-1:0]    color;
    logic [pch_pkg::COLOR_BITS-1:0]    slot_lut [pch_pkg::COLOR_SPAN];
    logic                              has_page;
    logic                              sel_ok;

    // Routing is precomputed on the register write so the per-item path is an AND-OR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route <= pch_pkg::color_route(pch_pkg::COLOR_MASK_RESET, PAGE_OFFSET_BITS);
        end else if (i_cfg_we) begin
            r_route <= pch_pkg::color_route(i_cfg_wdata, PAGE_OFFSET_BITS);
        end
    end

    assign frame    = i_item.map_entry[pch_pkg::PRESENT_BIT] ?
                      i_item.map_entry[FRAME_BITS-1:0] : '0;
    assign has_page = (frame != '0);

    // Frame bits lined up with physical address bit positions.
    for (genvar c = 0; c < pch_pkg::MASK_BITS; c++) begin : g_align
        if (c >= PAGE_OFFSET_BITS && c - PAGE_OFFSET_BITS < FRAME_BITS) begin : g_in
            assign fbit[c] = frame[c - PAGE_OFFSET_BITS];
        end else begin : g_out
            assign fbit[c] = 1'b0;
        end
    end

    always_comb begin
        color = '0;
        for (int k = 0; k < pch_pkg::COLOR_BITS; k++) begin
            for (int c = 0; c < pch_pkg::MASK_BITS; c++) begin
                if (r_route[c][k] && fbit[c]) begin
                    color[k] = 1'b1;
                end
            end
        end
    end

    // color modulo bin count, as a constant table
    for (genvar g = 0; g < pch_pkg::COLOR_SPAN; g++) begin : g_mod
        assign slot_lut[g] = pch_pkg::COLOR_BITS'(g % NUM_COLORS);
    end

    assign sel_ok = ({4'b0, i_item.bin_select} < 9'(NUM_COLORS));

    always_comb begin
        if (i_item.action) begin
            o_cmd.op      = pch_pkg::OP_READ;
            o_cmd.color   = i_item.bin_select;
            o_cmd.slot    = i_item.bin_select;
            o_cmd.slot_ok = sel_ok;
        end else if (has_page) begin
            o_cmd.op      = pch_pkg::OP_ADD;
            o_cmd.color   = color;
            o_cmd.slot    = slot_lut[color];
            o_cmd.slot_ok = 1'b1;
        end else begin
            o_cmd.op      = pch_pkg::OP_SKIP;
            o_cmd.color   = '0;
            o_cmd.slot    = '0;
            o_cmd.slot_ok = 1'b0;
        end
    end

endmodule

>>> rtl/core/pch_queue.sv
module pch_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pch_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pch_pkg::t_cmd o_data
);

    localparam int DEPTH = pch_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pch_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/pch_back.sv
`include "page_color_histogram_macros.svh"

module pch_back #(
    parameter int NUM_COLORS  = pch_pkg::NUM_COLORS_DEF,
    parameter int COUNT_WIDTH = pch_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pch_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output pch_pkg::t_result o_result
);

    // Colors are 5 bits, so no more than 32 bins can ever be reached.
    localparam int DEPTH = (NUM_COLORS < pch_pkg::COLOR_SPAN) ? NUM_COLORS
                                                              : pch_pkg::COLOR_SPAN;
    localparam int IW    = $clog2(DEPTH);

    logic [COUNT_WIDTH-1:0] r_bins [DEPTH];
    logic [COUNT_WIDTH-1:0] r_total;
    logic                   r_valid;
    pch_pkg::t_result       r_result;

    logic                   pop;
    logic [IW-1:0]          idx;
    logic [COUNT_WIDTH-1:0] bin_cur;
    logic [COUNT_WIDTH-1:0] bin_inc;
    logic [COUNT_WIDTH-1:0] total_inc;
    pch_pkg::t_result       n_result;

    assign pop       = i_cmd_valid && (!r_valid || !i_stall);
    assign o_cmd_pop = pop;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    assign idx       = i_cmd.slot[IW-1:0];
    assign bin_cur   = i_cmd.slot_ok ? r_bins[idx] : '0;
    assign bin_inc   = (bin_cur == {COUNT_WIDTH{1'b1}}) ? bin_cur : bin_cur + 1'b1;
    assign total_inc = (r_total == {COUNT_WIDTH{1'b1}}) ? r_total : r_total + 1'b1;

    always_comb begin
        case (i_cmd.op)
            pch_pkg::OP_ADD: begin
                n_result.counted     = 1'b1;
                n_result.color       = i_cmd.color;
                n_result.bin_count   = pch_pkg::out_count(64'(bin_inc));
                n_result.total_count = pch_pkg::out_count(64'(total_inc));
            end
            pch_pkg::OP_READ: begin
                n_result.counted     = 1'b0;
                n_result.color       = i_cmd.color;
                n_result.bin_count   = pch_pkg::out_count(64'(bin_cur));
                n_result.total_count = pch_pkg::out_count(64'(r_total));
            end
            default: begin
                n_result.counted     = 1'b0;
                n_result.color       = '0;
                n_result.bin_count   = '0;
                n_result.total_count = pch_pkg::out_count(64'(r_total));
            end
        endcase
    end

    // Read-modify-write of the bin happens in the pop cycle, so back-to-back
    // adds to one bin see each other without forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
            for (int b = 0; b < DEPTH; b++) begin
                r_bins[b] <= '0;
            end
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (pop && i_cmd.op == pch_pkg::OP_ADD) begin
                r_total     <= total_inc;
                r_bins[idx] <= bin_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_result <= n_result;
        end
    end

    `PCH_ASSERT_HOLDS(a_no_pop_over_held, i_clk, i_rst_n, r_valid && i_stall, !pop)
    `PCH_ASSERT_NEXT(a_add_moves_total, i_clk, i_rst_n, pop && i_cmd.op == pch_pkg::OP_ADD, (r_total != $past(r_total)) || (&r_total))
    `PCH_ASSERT_NEXT(a_other_keeps_total, i_clk, i_rst_n, pop && i_cmd.op != pch_pkg::OP_ADD, $stable(r_total))

endmodule

>>> rtl/core/page_color_histogram.sv
// An item passes the queue register and then the result register on its way to o_valid.
// One item per cycle while i_stall is low; the bin read-modify-write is done at pop.
// A two-entry queue between classify and count lets each side stall on its own.
// Reset (synchronous, i_rst_n low): all bins and the total clear at once, the mask
// returns to 0x1c000, the queue empties and no result is pending.
module page_color_histogram #(
    parameter int NUM_COLORS       = pch_pkg::NUM_COLORS_DEF,
    parameter int COUNT_WIDTH      = pch_pkg::COUNT_WIDTH_DEF,
    parameter int PAGE_OFFSET_BITS = pch_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int FRAME_BITS       = pch_pkg::FRAME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // color mask register
    input  logic                          i_cfg_we,
    input  logic [pch_pkg::MASK_BITS-1:0] i_cfg_wdata,
    // item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  pch_pkg::t_item                i_item,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output pch_pkg::t_result              o_result
);

    pch_pkg::t_cmd front_cmd;
    pch_pkg::t_cmd queue_cmd;
    logic          queue_full;
    logic          queue_valid;
    logic          queue_pop;
    logic          push;

    // Front: decode the action, extract the frame, gather the color bits and
    // fold the color onto a bin index.
    pch_front #(
        .NUM_COLORS       (NUM_COLORS),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .FRAME_BITS       (FRAME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .o_cmd       (front_cmd)
    );

    // Input stalls only when the queue is full; that is a registered flag.
    assign o_stall = queue_full;
    assign push    = i_valid && !queue_full;

    pch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    // Back: saturating counter update and the registered result stage. A new
    // command is taken whenever the output register is empty or being drained.
    pch_back #(
        .NUM_COLORS  (NUM_COLORS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pch_pkg::*;

    // Block geometry at its default parameters.
    localparam int NUM_BINS = NUM_COLORS_DEF;
    localparam int PAGE_OFS = PAGE_OFFSET_BITS_DEF;
    localparam int FRAME_W  = FRAME_BITS_DEF;

    // Action codes of the item.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    // Settle time after the last result, as a margin.
    localparam int DRAIN_CYCLES = 6;
    // Length of the deliberate long receiver hold-off.
    localparam int LONG_HOLD    = 60;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [MASK_BITS-1:0] i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_item                i_item      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_result              o_result;

    page_color_histogram i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    initial begin
        forever #2ns i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Histogram shadow: our own copy of the bins, the total and the mask.
    // ------------------------------------------------------------------
    logic [OUT_BITS-1:0]  bin_tally [NUM_BINS] = '{default: '0};
    logic [OUT_BITS-1:0]  page_tally = '0;
    logic [MASK_BITS-1:0] mask_shadow = COLOR_MASK_RESET;

    t_item   entry_backlog [$];   // items waiting to be offered, front is on the bus
    t_result owed_results  [$];   // results predicted but not yet seen

    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  sent_last    = 1'b0;     // item transfer happened at the latest rising edge
    bit  calm         = 1'b0;     // last part of the run: no idling on either side
    int  hold_req     = 0;        // bumped to ask the receiver for a long hold-off
    int  hold_seen    = 0;
    int  hold_left    = 0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;

    // Apply one item to the shadow histogram and return the result it owes.
    function automatic t_result tally_page(input t_item it);
        t_result              r;
        logic [FRAME_W-1:0]   frame;
        logic [COLOR_BITS-1:0] hue;
        int unsigned          used;
        int unsigned          slot;
        r = '0;
        if (it.action == ACT_READ) begin
            // Reads report the selected bin as is; counted stays low.
            r.color       = it.bin_select;
            r.bin_count   = (int'(it.bin_select) < NUM_BINS) ? bin_tally[it.bin_select] : '0;
            r.total_count = page_tally;
            return r;
        end
        // Frame is taken only when the present bit is set.
        frame = it.map_entry[PRESENT_BIT] ? it.map_entry[FRAME_W-1:0] : '0;
        if (frame == '0) begin
            // Not a page: nothing moves, only the total is reported.
            r.total_count = page_tally;
            return r;
        end
        // Bit gather: usable mask bits (at or above the page offset), low to high,
        // each feed the next color bit; past the fifth they are dropped.
        hue  = '0;
        used = 0;
        for (int c = PAGE_OFS; c < MASK_BITS; c++) begin
            if (mask_shadow[c] && used < COLOR_BITS) begin
                if (c - PAGE_OFS < FRAME_W) begin
                    hue[used] = frame[c - PAGE_OFS];
                end
                used++;
            end
        end
        slot = hue % NUM_BINS;
        if (page_tally != '1) begin
            page_tally++;
        end
        if (bin_tally[slot] != '1) begin
            bin_tally[slot]++;
        end
        r.counted     = 1'b1;
        r.color       = hue;
        r.bin_count   = bin_tally[slot];
        r.total_count = page_tally;
        return r;
    endfunction

    function automatic t_item mk_item(input logic act, input logic [ENTRY_BITS-1:0] entry,
                                      input logic [COLOR_BITS-1:0] sel);
        t_item it;
        it.action     = act;
        it.map_entry  = entry;
        it.bin_select = sel;
        return it;
    endfunction

    // Mostly real pages with random frames; the rest reads, zero frames,
    // absent entries and raw noise.
    task automatic queue_random(input int n);
        t_item       it;
        int unsigned pick;
        repeat (n) begin
            pick          = $urandom_range(0, 99);
            it.map_entry  = {$urandom, $urandom};
            it.bin_select = 5'($urandom_range(0, 31));
            it.action     = ACT_ADD;
            if (pick < 20) begin
                it.action = ACT_READ;
            end else if (pick < 80) begin
                it.map_entry[PRESENT_BIT] = 1'b1;
            end else if (pick < 88) begin
                it.map_entry[PRESENT_BIT]   = 1'b1;
                it.map_entry[FRAME_W-1:0]   = '0;
            end else if (pick < 94) begin
                it.map_entry[PRESENT_BIT] = 1'b0;
            end
            entry_backlog.push_back(it);
        end
    endtask

    // Wait until the sender has nothing left and every owed result is in.
    task automatic drain();
        do @(negedge i_clk);
        while (entry_backlog.size() != 0 || i_valid || owed_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mask writes happen only with the block idle.
    task automatic write_mask(input logic [MASK_BITS-1:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        mask_shadow  = m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Item driver: offers the backlog front, holds it while stalled,
    // inserts random idle bursts between transfers.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !sent_last) begin
            // stalled: payload and valid stay put
        end else if (tx_gap > 0) begin
            tx_gap  = tx_gap - 1;
            i_valid <= 1'b0;
        end else if (entry_backlog.size() == 0) begin
            i_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            tx_gap  = $urandom_range(1, 7) - 1;
            i_valid <= 1'b0;
        end else begin
            i_valid <= 1'b1;
            i_item  <= entry_backlog[0];
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus one long hold-off on request
    // so the internal queue fills and the input side backs up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            i_stall   <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  = rx_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_gap  = $urandom_range(1, 7) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each item transfer, checks each result transfer
    // against the oldest prediction, and watches for a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      took_result;
        sent_last   = 1'b0;
        took_result = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                owed_results.push_back(tally_page(i_item));
                void'(entry_backlog.pop_front());
                sent_last = 1'b1;
            end
            if (o_valid && !i_stall) begin
                took_result = 1'b1;
                if (owed_results.size() == 0) begin
                    $error("result transfer with nothing owed: %p", o_result);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_result.counted !== want.counted) begin
                        $error("counted: expected %0h actual %0h", want.counted,
                               o_result.counted);
                        fail_count++;
                    end
                    if (o_result.color !== want.color) begin
                        $error("color: expected %0h actual %0h", want.color, o_result.color);
                        fail_count++;
                    end
                    if (o_result.bin_count !== want.bin_count) begin
                        $error("bin_count: expected %0h actual %0h", want.bin_count,
                               o_result.bin_count);
                        fail_count++;
                    end
                    if (o_result.total_count !== want.total_count) begin
                        $error("total_count: expected %0h actual %0h", want.total_count,
                               o_result.total_count);
                        fail_count++;
                    end
                end
            end
            quiet_cycles = (sent_last || took_result) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases.
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [MASK_BITS-1:0] mask_plan [10];
        mask_plan[0] = 32'h0000_0000;   // no color bits: everything lands in bin 0
        mask_plan[1] = 32'hFFFF_FFFF;   // low bits skipped, only five usable kept
        mask_plan[2] = 32'h0000_0FFF;   // only bits below the page offset
        mask_plan[3] = 32'h8000_0000;   // top address bit alone
        mask_plan[4] = 32'hF800_0000;   // five highest bits
        mask_plan[5] = 32'h00AA_5000;
        mask_plan[6] = $urandom;
        mask_plan[7] = $urandom;
        mask_plan[8] = $urandom & 32'hFFFF_F000;
        mask_plan[9] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset mask (color from frame bits 2..4).
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd0));
        entry_backlog.push_back(mk_item(ACT_READ, '1, 5'd31));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h0000_0000_0000_0000, 5'd0));
        // present but zero frame, and high junk bits with zero frame
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_0000, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'hFF80_0000_0000_0000, 5'd31));
        // absent with a full frame
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_0001, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_0004, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_0008, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_0010, 5'd0));
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8000_0000_0000_001C, 5'd0));
        // highest frame bit only
        entry_backlog.push_back(mk_item(ACT_ADD, 64'h8040_0000_0000_0000, 5'd0));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd0));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd1));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd2));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd4));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd7));
        entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd31));
        drain();

        // Receiver holds off for a long stretch while the sender keeps going;
        // drain() afterwards is the sender pause until all results are in.
        hold_req = hold_req + 1;
        queue_random(40);
        drain();

        foreach (mask_plan[k]) begin
            write_mask(mask_plan[k]);
            entry_backlog.push_back(mk_item(ACT_ADD, '1, 5'd0));
            entry_backlog.push_back(mk_item(ACT_READ, '0, 5'd31));
            queue_random(50);
        end

        // Closing stretch at full rate on both sides, back at the reset mask.
        calm = 1'b1;
        write_mask(COLOR_MASK_RESET);
        queue_random(60);
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
